FILE: sv/orb_pkg.sv
package orb_pkg;

  // Operation codes carried on in_kind; the unused code acts as a query
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

endpackage

FILE: sv/orb_ram.sv
module orb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/overwrite_oldest_ring_buffer.sv
// Overwriting ring buffer of records.
// Command channel: an operation is taken at a rising edge with start high and
// busy low. busy is always low, so one push, pop or query is taken per cycle.
// in_kind selects push (store in_record_in), pop (remove oldest) or query;
// the unused kind code behaves as a query.
// Result channel: exactly one result beat per operation, shown for one cycle
// with out_valid high, in the cycle right after the operation was taken
// (throughput 1 per cycle). The slot store is a RAM with a
// registered read; the popped record comes straight from its read register.
// A push into a full buffer overwrites the oldest record and flags
// out_dropped_oldest. Every beat also carries the newest record still held
// and the fill count after the operation.
// Reset clears both positions, so the buffer is empty; slot contents are not
// cleared and need no clearing pass, since only written slots are read.
// The receiver cannot stall: each beat is taken in the cycle it is shown.
module overwrite_oldest_ring_buffer #(
  parameter int DEPTH        = 16,
  parameter int RECORD_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [RECORD_WIDTH-1:0]    in_record_in,
  output logic                       out_valid,
  output logic                       out_popped_valid,
  output logic [RECORD_WIDTH-1:0]    out_popped_record,
  output logic                       out_newest_valid,
  output logic [RECORD_WIDTH-1:0]    out_newest_record,
  output logic [$clog2(DEPTH):0]     out_fill_count,
  output logic                       out_dropped_oldest
);
  import orb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;

  logic                    accept;
  logic [PW-1:0]           wr_pos_r, wr_pos_nxt;
  logic [PW-1:0]           rd_pos_r, rd_pos_nxt;
  logic [RECORD_WIDTH-1:0] newest_r, newest_nxt;
  logic [PW-1:0]           count_now;
  logic [PW-1:0]           count_nxt;
  logic                    do_push;
  logic                    do_pop;
  logic                    dropped;

  logic                    out_valid_r;
  logic                    popped_valid_r;
  logic                    newest_valid_r;
  logic [RECORD_WIDTH-1:0] newest_record_r;
  logic [PW-1:0]           fill_count_r;
  logic                    dropped_r;
  logic [RECORD_WIDTH-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Positions wrap modulo twice the depth, so full and empty differ
  assign count_now = wr_pos_r - rd_pos_r;

  // Decode the operation and the pointer moves
  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    dropped    = 1'b0;
    wr_pos_nxt = wr_pos_r;
    rd_pos_nxt = rd_pos_r;
    newest_nxt = newest_r;
    if (accept) begin
      case (in_kind)
        KIND_PUSH: begin
          do_push    = 1'b1;
          wr_pos_nxt = wr_pos_r + PW'(1);
          newest_nxt = in_record_in;
          if (count_now == PW'(DEPTH)) begin
            dropped    = 1'b1;
            rd_pos_nxt = rd_pos_r + PW'(1);
          end
        end
        KIND_POP: begin
          if (count_now != '0) begin
            do_pop     = 1'b1;
            rd_pos_nxt = rd_pos_r + PW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign count_nxt = wr_pos_nxt - rd_pos_nxt;

  // Slot store: push writes at the write slot, pop reads the oldest slot
  orb_ram #(
    .WIDTH (RECORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_pos_r[AW-1:0]),
    .wdata (in_record_in),
    .re    (do_pop),
    .raddr (rd_pos_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
      rd_pos_r <= '0;
    end else begin
      wr_pos_r <= wr_pos_nxt;
      rd_pos_r <= rd_pos_nxt;
    end
  end

  // Newest record and result fields
  always_ff @(posedge clk) begin
    newest_r <= newest_nxt;
    if (accept) begin
      popped_valid_r  <= do_pop;
      newest_valid_r  <= (count_nxt != '0);
      newest_record_r <= (count_nxt != '0) ? newest_nxt : '0;
      fill_count_r    <= count_nxt;
      dropped_r       <= dropped;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_popped_valid   = popped_valid_r;
  assign out_popped_record  = popped_valid_r ? ram_rdata : '0;
  assign out_newest_valid   = newest_valid_r;
  assign out_newest_record  = newest_record_r;
  assign out_fill_count     = fill_count_r;
  assign out_dropped_oldest = dropped_r;

  // Every taken operation gives a beat on the next cycle
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && start && !busy |=> out_valid)
    else $error("operation without result beat");

  // Fill count never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_count <= ($clog2(DEPTH)+1)'(DEPTH))
    else $error("fill count above depth");

  // An overwrite leaves the buffer full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped_oldest |-> out_fill_count == ($clog2(DEPTH)+1)'(DEPTH))
    else $error("overwrite without full buffer");

  // Newest valid tracks a nonzero fill count
  a_newest_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_newest_valid == (out_fill_count != '0))
    else $error("newest valid disagrees with fill count");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import orb_pkg::*;

  localparam int DEPTH = 16;
  localparam int RW = 64;
  localparam int PW = $clog2(DEPTH) + 1;
  localparam int NUM_RANDOM_OPS = 2000;
  localparam int STALL_LIMIT = 1000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]    kind;
    logic [RW-1:0] rec;
    bit            drain;
  } ring_op_t;

  typedef struct {
    logic          popped_valid;
    logic [RW-1:0] popped_record;
    logic          newest_valid;
    logic [RW-1:0] newest_record;
    logic [PW-1:0] fill_count;
    logic          dropped_oldest;
  } ring_status_t;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    in_kind = KIND_QUERY;
  logic [RW-1:0] in_record_in = '0;
  logic          out_valid;
  logic          out_popped_valid;
  logic [RW-1:0] out_popped_record;
  logic          out_newest_valid;
  logic [RW-1:0] out_newest_record;
  logic [PW-1:0] out_fill_count;
  logic          out_dropped_oldest;

  // Operations waiting to be driven, and status beats still owed by the block
  ring_op_t     op_q[$];
  ring_status_t status_q[$];

  // Shadow copy of the ring contents and positions
  logic [RW-1:0] model_slots[DEPTH];
  logic [PW-1:0] model_wr_pos = '0;
  logic [PW-1:0] model_rd_pos = '0;

  int  fail_count = 0;
  int  gap_left = 0;
  bit  draining = 1'b0;
  bit  steady_run = 1'b0;
  int  stall_cycles = 0;

  overwrite_oldest_ring_buffer #(
    .DEPTH        (DEPTH),
    .RECORD_WIDTH (RW)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_record_in       (in_record_in),
    .out_valid          (out_valid),
    .out_popped_valid   (out_popped_valid),
    .out_popped_record  (out_popped_record),
    .out_newest_valid   (out_newest_valid),
    .out_newest_record  (out_newest_record),
    .out_fill_count     (out_fill_count),
    .out_dropped_oldest (out_dropped_oldest)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one operation to the shadow ring and queue the status it yields
  function automatic void ring_apply_op(logic [1:0] kind, logic [RW-1:0] rec);
    ring_status_t st;
    logic [PW-1:0] held;
    logic [PW-1:0] last_pos;
    st = '{default: '0};
    if (kind == KIND_PUSH) begin
      model_slots[model_wr_pos[PW-2:0]] = rec;
      model_wr_pos = model_wr_pos + PW'(1);
      held = model_wr_pos - model_rd_pos;
      // overfull: overwrite the oldest record
      if (held > PW'(DEPTH) || held == '0) begin
        model_rd_pos = model_rd_pos + PW'(1);
        st.dropped_oldest = 1'b1;
      end
    end else if (kind == KIND_POP) begin
      held = model_wr_pos - model_rd_pos;
      if (held != '0) begin
        st.popped_record = model_slots[model_rd_pos[PW-2:0]];
        st.popped_valid = 1'b1;
        model_rd_pos = model_rd_pos + PW'(1);
      end
    end
    held = model_wr_pos - model_rd_pos;
    st.fill_count = held;
    if (held != '0) begin
      last_pos = model_wr_pos - PW'(1);
      st.newest_valid = 1'b1;
      st.newest_record = model_slots[last_pos[PW-2:0]];
    end
    status_q.push_back(st);
  endfunction

  function automatic logic [RW-1:0] rand_record();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic void queue_op(logic [1:0] kind, logic [RW-1:0] rec, bit drain);
    ring_op_t op;
    op.kind = kind;
    op.rec = rec;
    op.drain = drain;
    op_q.push_back(op);
  endfunction

  // Driver: takes operations from op_q, with random gaps and drain pauses
  always @(posedge clk) begin
    bit       accepted;
    bit       nxt_start;
    int       sel;
    ring_op_t op;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        ring_apply_op(in_kind, in_record_in);
        if ($urandom_range(0, 99) == 0) steady_run = !steady_run;
        sel = $urandom_range(0, 99);
        if (steady_run || sel < 60) gap_left = 0;
        else if (sel < 92) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(8, 40);
      end
      // channel free: pick what goes next
      if (!(start && !accepted)) begin
        nxt_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (draining) begin
          if (status_q.size() == 0) draining = 1'b0;
        end else if (op_q.size() > 0) begin
          op = op_q.pop_front();
          if (op.drain) begin
            draining = 1'b1;
          end else begin
            in_kind <= op.kind;
            in_record_in <= op.rec;
            nxt_start = 1'b1;
          end
        end
        start <= nxt_start;
      end
    end
  end

  // Monitor: every result beat is checked against the oldest expected status
  always @(posedge clk) begin
    ring_status_t exp_st;
    if (rst_n && out_valid) begin
      if (status_q.size() == 0) begin
        $error("result beat with no operation outstanding");
        fail_count++;
      end else begin
        exp_st = status_q.pop_front();
        if (out_popped_valid !== exp_st.popped_valid) begin
          $error("popped_valid: expected %b, got %b", exp_st.popped_valid, out_popped_valid);
          fail_count++;
        end
        if (out_popped_record !== exp_st.popped_record) begin
          $error("popped_record: expected %h, got %h", exp_st.popped_record,
                 out_popped_record);
          fail_count++;
        end
        if (out_newest_valid !== exp_st.newest_valid) begin
          $error("newest_valid: expected %b, got %b", exp_st.newest_valid, out_newest_valid);
          fail_count++;
        end
        if (out_newest_record !== exp_st.newest_record) begin
          $error("newest_record: expected %h, got %h", exp_st.newest_record,
                 out_newest_record);
          fail_count++;
        end
        if (out_fill_count !== exp_st.fill_count) begin
          $error("fill_count: expected %0d, got %0d", exp_st.fill_count, out_fill_count);
          fail_count++;
        end
        if (out_dropped_oldest !== exp_st.dropped_oldest) begin
          $error("dropped_oldest: expected %b, got %b", exp_st.dropped_oldest,
                 out_dropped_oldest);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long with no beat on either side ends the run
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n;
    int phase_len;
    int push_pct;
    int pop_pct;
    int sel;

    // Empty buffer: query, pop with nothing held, unused kind code
    queue_op(KIND_QUERY, '1, 1'b0);
    queue_op(KIND_POP, '1, 1'b0);
    queue_op(KIND_UNUSED, '1, 1'b0);
    // Fill to full with edge patterns, then one push past full
    queue_op(KIND_PUSH, '0, 1'b0);
    queue_op(KIND_PUSH, '1, 1'b0);
    queue_op(KIND_PUSH, {RW/2{2'b10}}, 1'b0);
    queue_op(KIND_PUSH, {RW/2{2'b01}}, 1'b0);
    repeat (DEPTH - 4) queue_op(KIND_PUSH, rand_record(), 1'b0);
    queue_op(KIND_PUSH, {1'b1, {(RW-1){1'b0}}}, 1'b0);
    queue_op(KIND_UNUSED, '0, 1'b0);
    queue_op(KIND_POP, '0, 1'b0);
    queue_op(KIND_QUERY, '0, 1'b0);
    // hold off until the block has answered everything so far
    queue_op(KIND_QUERY, '0, 1'b1);

    // Random phases biased toward filling, draining or mixed traffic
    n = 0;
    while (n < NUM_RANDOM_OPS) begin
      phase_len = $urandom_range(20, 150);
      case ($urandom_range(0, 3))
        0: begin push_pct = 80; pop_pct = 15; end
        1: begin push_pct = 20; pop_pct = 72; end
        2: begin push_pct = 45; pop_pct = 45; end
        default: begin push_pct = 60; pop_pct = 30; end
      endcase
      repeat (phase_len) begin
        sel = $urandom_range(0, 99);
        if (sel < push_pct) queue_op(KIND_PUSH, rand_record(), 1'b0);
        else if (sel < push_pct + pop_pct) queue_op(KIND_POP, rand_record(), 1'b0);
        else if (sel % 2 == 0) queue_op(KIND_QUERY, rand_record(), 1'b0);
        else queue_op(KIND_UNUSED, rand_record(), 1'b0);
        n++;
      end
      if ($urandom_range(0, 3) == 0) queue_op(KIND_QUERY, '0, 1'b1);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all operations to go out, then for all status beats
    while (op_q.size() != 0 || start || draining) @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/orb_pkg.sv
sv/orb_ram.sv
sv/overwrite_oldest_ring_buffer.sv
bench/tb_top.sv
